// ===== src/msp_pkg.sv =====
// Shared types and constants for the MIDI stream parser.
`default_nettype none

package msp_pkg;

   // Byte classes of the MIDI wire format
   localparam logic [7:0] MIDI_REALTIME_MIN = 8'hF8;
   localparam logic [7:0] MIDI_SYSEX_END    = 8'hF7;
   localparam logic [7:0] MIDI_SYSEX_START  = 8'hF0;
   localparam logic [7:0] MIDI_STATUS_MASK  = 8'hF0;
   localparam logic [7:0] MIDI_PROG_CHANGE  = 8'hC0;
   localparam logic [7:0] MIDI_CHAN_PRESS   = 8'hD0;
   localparam logic [3:0] MIDI_CHAN_MASK    = 4'd15;

   // Result kinds
   localparam logic MSG_VOICE = 1'b0;
   localparam logic MSG_SYSEX = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EMIT
   } msp_state_type;

   typedef struct packed {
      logic        message_kind;
      logic [4:0]  channel_number;
      logic [7:0]  status_type;
      logic [6:0]  first_data;
      logic [6:0]  second_data;
      logic [6:0]  byte_count;
      logic [5:0]  byte_index;
      logic        payload_valid;
      logic        last_of_run;
      logic [31:0] dropped_count;
   } msp_beat_type;

endpackage

`default_nettype wire

// ===== src/msp_sysex_ram.sv =====
// SysEx payload store: one write port, one registered read port.
`default_nettype none

module msp_sysex_ram #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [6:0]    wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [6:0]    rd_data
);

   logic [6:0] store_ff [DEPTH];
   logic [6:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // hold read data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/msp_core.sv =====
// Parser core: byte holding register, running status, sysex fill and readout sequencer.
`default_nettype none

module msp_core #(
   parameter int SYSEX_DEPTH = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 byte_valid,
   output logic                      byte_ready,
   input  wire logic [7:0]           byte_data,
   output logic                      beat_valid,
   input  wire logic                 beat_ready,
   output msp_pkg::msp_beat_type     beat
);

   localparam int AW = (SYSEX_DEPTH > 1) ? $clog2(SYSEX_DEPTH) : 1;
   localparam int FW = $clog2(SYSEX_DEPTH + 1);

   msp_pkg::msp_state_type state_ff, state_in;

   logic          byte_vld_ff, byte_vld_in;
   logic [7:0]    byte_ff;
   logic [7:0]    rs_ff, rs_in;
   logic          two_ff, two_in;
   logic          rcv_ff, rcv_in;
   logic [6:0]    held_ff, held_in;
   logic          sx_ff, sx_in;
   logic          ovf_ff, ovf_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [FW-1:0] idx_ff, idx_in;
   logic [31:0]   drop_ff, drop_in;
   logic          consume;
   logic          wr_en;
   logic          rd_en;
   logic [6:0]    rd_data;

   logic          is_rt, is_data, is_f7, dump_start, dump_last;
   logic [7:0]    stype;

   assign is_rt      = byte_ff >= msp_pkg::MIDI_REALTIME_MIN;
   assign is_data    = !byte_ff[7];
   assign is_f7      = byte_ff == msp_pkg::MIDI_SYSEX_END;
   assign dump_start = byte_vld_ff && sx_ff && is_f7 && !ovf_ff && (fill_ff != '0);
   assign dump_last  = FW'(idx_ff + FW'(1)) == fill_ff;
   assign stype      = byte_ff & msp_pkg::MIDI_STATUS_MASK;
   assign byte_ready = !byte_vld_ff;

   msp_sysex_ram #(
      .DEPTH (SYSEX_DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_ff[AW-1:0]),
      .wr_data (byte_ff[6:0]),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         msp_pkg::ST_IDLE: begin
            if (dump_start) begin
               state_in = msp_pkg::ST_READ;
            end
         end
         msp_pkg::ST_READ: begin
            state_in = msp_pkg::ST_EMIT;
         end
         msp_pkg::ST_EMIT: begin
            if (beat_ready) begin
               state_in = dump_last ? msp_pkg::ST_IDLE : msp_pkg::ST_READ;
            end
         end
         default: begin
            state_in = msp_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      rs_in      = rs_ff;
      two_in     = two_ff;
      rcv_in     = rcv_ff;
      held_in    = held_ff;
      sx_in      = sx_ff;
      ovf_in     = ovf_ff;
      fill_in    = fill_ff;
      idx_in     = idx_ff;
      drop_in    = drop_ff;
      consume    = 1'b0;
      wr_en      = 1'b0;
      rd_en      = 1'b0;
      beat_valid = 1'b0;

      beat                = '0;
      beat.message_kind   = msp_pkg::MSG_VOICE;
      beat.channel_number = 5'({1'b0, rs_ff[3:0] & msp_pkg::MIDI_CHAN_MASK} + 5'd1);
      beat.status_type    = rs_ff & msp_pkg::MIDI_STATUS_MASK;
      beat.first_data     = two_ff ? held_ff : byte_ff[6:0];
      beat.second_data    = two_ff ? byte_ff[6:0] : 7'd0;
      beat.byte_count     = two_ff ? 7'd2 : 7'd1;
      beat.payload_valid  = 1'b1;
      beat.last_of_run    = 1'b1;
      beat.dropped_count  = drop_ff;

      case (state_ff)
         msp_pkg::ST_IDLE: begin
            if (byte_vld_ff && is_rt) begin
               consume = 1'b1;
            end else if (byte_vld_ff && sx_ff && is_f7) begin
               if (ovf_ff) begin
                  consume = 1'b1;
                  sx_in   = 1'b0;
                  ovf_in  = 1'b0;
                  fill_in = '0;
               end else if (fill_ff == '0) begin
                  beat_valid         = 1'b1;
                  beat.message_kind  = msp_pkg::MSG_SYSEX;
                  beat.channel_number = 5'd0;
                  beat.status_type   = msp_pkg::MIDI_SYSEX_START;
                  beat.first_data    = 7'd0;
                  beat.second_data   = 7'd0;
                  beat.byte_count    = 7'd0;
                  beat.payload_valid = 1'b0;
                  if (beat_ready) begin
                     consume = 1'b1;
                     sx_in   = 1'b0;
                     fill_in = '0;
                  end
               end else begin
                  idx_in = '0;
               end
            end else if (byte_vld_ff && sx_ff && is_data) begin
               consume = 1'b1;
               if (!ovf_ff) begin
                  if (fill_ff < FW'(SYSEX_DEPTH)) begin
                     wr_en   = 1'b1;
                     fill_in = FW'(fill_ff + FW'(1));
                  end else begin
                     // store full: drop the message and count it
                     ovf_in  = 1'b1;
                     fill_in = '0;
                     drop_in = drop_ff + 32'd1;
                  end
               end
            end else if (byte_vld_ff && !is_data) begin
               // any other non-realtime status byte ends an open sysex, then acts normally
               consume = 1'b1;
               sx_in   = 1'b0;
               ovf_in  = 1'b0;
               fill_in = '0;
               rcv_in  = 1'b0;
               if (byte_ff >= msp_pkg::MIDI_SYSEX_START) begin
                  rs_in  = 8'd0;
                  two_in = 1'b0;
                  if (byte_ff == msp_pkg::MIDI_SYSEX_START) begin
                     sx_in = 1'b1;
                  end
               end else begin
                  rs_in  = byte_ff;
                  two_in = !(stype == msp_pkg::MIDI_PROG_CHANGE ||
                             stype == msp_pkg::MIDI_CHAN_PRESS);
               end
            end else if (byte_vld_ff) begin
               if (rs_ff == 8'd0) begin
                  consume = 1'b1;
               end else if (!rcv_ff && two_ff) begin
                  consume = 1'b1;
                  held_in = byte_ff[6:0];
                  rcv_in  = 1'b1;
               end else begin
                  beat_valid = 1'b1;
                  if (beat_ready) begin
                     consume = 1'b1;
                     rcv_in  = 1'b0;
                  end
               end
            end
         end
         msp_pkg::ST_READ: begin
            rd_en = 1'b1;
         end
         msp_pkg::ST_EMIT: begin
            beat_valid          = 1'b1;
            beat.message_kind   = msp_pkg::MSG_SYSEX;
            beat.channel_number = 5'd0;
            beat.status_type    = msp_pkg::MIDI_SYSEX_START;
            beat.first_data     = rd_data;
            beat.second_data    = 7'd0;
            beat.byte_count     = 7'(fill_ff);
            beat.byte_index     = 6'(idx_ff);
            beat.last_of_run    = dump_last;
            if (beat_ready) begin
               if (dump_last) begin
                  consume = 1'b1;
                  sx_in   = 1'b0;
                  ovf_in  = 1'b0;
                  fill_in = '0;
               end else begin
                  idx_in = FW'(idx_ff + FW'(1));
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      byte_vld_in = byte_vld_ff;
      if (byte_valid && byte_ready) begin
         byte_vld_in = 1'b1;
      end else if (consume) begin
         byte_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= msp_pkg::ST_IDLE;
         byte_vld_ff <= 1'b0;
         rs_ff       <= 8'd0;
         two_ff      <= 1'b0;
         rcv_ff      <= 1'b0;
         sx_ff       <= 1'b0;
         ovf_ff      <= 1'b0;
         fill_ff     <= '0;
         idx_ff      <= '0;
         drop_ff     <= 32'd0;
      end else begin
         state_ff    <= state_in;
         byte_vld_ff <= byte_vld_in;
         rs_ff       <= rs_in;
         two_ff      <= two_in;
         rcv_ff      <= rcv_in;
         sx_ff       <= sx_in;
         ovf_ff      <= ovf_in;
         fill_ff     <= fill_in;
         idx_ff      <= idx_in;
         drop_ff     <= drop_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
      if (byte_valid && byte_ready) begin
         byte_ff <= byte_data;
      end
   end

endmodule

`default_nettype wire

// ===== src/midi_stream_parser.sv =====
// Top level of the MIDI stream parser: core, sysex store and result register.
//
//   channel | direction | tdata                                 | tuser / tlast
//   req     | in        | byte_in[7:0]                          | -
//   rsp     | out       | channel, status, data1, data2, count, | kind, payload_valid /
//           |           | index, dropped_count (72 bits)        | last_of_run
//
// A byte is taken into a holding register and decoded the next cycle; a new byte is
// taken only once the held byte is consumed. A closing 0xF7 reads the sysex store
// once per payload byte (memory read, then result register), and the 0xF7 is held
// until the last payload beat is taken, so no new byte enters during the readout.
// Reset is synchronous and clears running status, sysex state and the drop counter.
// A stalled rsp holds its beat; the next byte is still taken into the holding register.
`default_nettype none

module midi_stream_parser #(
   parameter int SYSEX_DEPTH = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] byte_in
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,   // [4:0] channel_number, [12:5] status_type,
                                         // [19:13] first_data, [26:20] second_data,
                                         // [33:27] byte_count, [39:34] byte_index,
                                         // [71:40] dropped_count
   output logic [1:0]       rsp_tuser,   // [0] message_kind, [1] payload_valid
   output logic             rsp_tlast
);

   msp_pkg::msp_beat_type beat;
   msp_pkg::msp_beat_type out_ff;
   logic                  beat_valid;
   logic                  beat_ready;
   logic                  out_vld_ff, out_vld_in;

   msp_core #(
      .SYSEX_DEPTH (SYSEX_DEPTH)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_tvalid),
      .byte_ready (req_tready),
      .byte_data  (req_tdata),
      .beat_valid (beat_valid),
      .beat_ready (beat_ready),
      .beat       (beat)
   );

   assign beat_ready = !out_vld_ff || rsp_tready;

   always_comb begin
      out_vld_in = out_vld_ff;
      if (beat_ready) begin
         out_vld_in = beat_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (beat_ready && beat_valid) begin
         out_ff <= beat;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {out_ff.dropped_count, out_ff.byte_index, out_ff.byte_count,
                        out_ff.second_data, out_ff.first_data, out_ff.status_type,
                        out_ff.channel_number};
   assign rsp_tuser  = {out_ff.payload_valid, out_ff.message_kind};
   assign rsp_tlast  = out_ff.last_of_run;

endmodule

`default_nettype wire

// ===== src/msp_checker.sv =====
// Port-level checks for the MIDI stream parser, bound to the top level.
`default_nettype none

module msp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [7:0]  req_tdata,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [71:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser,
   input wire logic        rsp_tlast
);

   // hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp beat changed while stalled");

   // voice results are single beats with a real channel and payload
   a_voice_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[0] == msp_pkg::MSG_VOICE) |->
         rsp_tlast && rsp_tuser[1] && (rsp_tdata[4:0] != 5'd0) && (rsp_tdata[39:34] == 6'd0))
      else $error("malformed voice result");

   // an empty sysex is one closing beat with zero count
   a_empty_sysex: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[0] == msp_pkg::MSG_SYSEX) && !rsp_tuser[1] |->
         rsp_tlast && (rsp_tdata[33:27] == 7'd0))
      else $error("malformed empty sysex result");

   // the last payload beat sits at the last index of the run
   a_sysex_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[0] == msp_pkg::MSG_SYSEX) && rsp_tuser[1] |->
         rsp_tlast == (7'({1'b0, rsp_tdata[39:34]} + 7'd1) == rsp_tdata[33:27]))
      else $error("sysex last flag out of place");

endmodule

bind midi_stream_parser msp_checker u_msp_checker (.*);

`default_nettype wire
